/* rtl/rvis_pkg.sv */
// Shared types and constants for the RV32I step core.
// Used by the front queue, the banked byte memory, the back executor and the top level.
package rvis_pkg;

  localparam int unsigned MemBytes = 65536;
  localparam int unsigned AddrW    = $clog2(MemBytes);
  localparam int unsigned MemRows  = MemBytes / 4;
  localparam int unsigned RowW     = $clog2(MemRows);

  localparam logic [31:0] HaltWord = 32'h0ff00513;

  localparam logic [6:0] OpLui    = 7'b0110111;
  localparam logic [6:0] OpAuipc  = 7'b0010111;
  localparam logic [6:0] OpJal    = 7'b1101111;
  localparam logic [6:0] OpJalr   = 7'b1100111;
  localparam logic [6:0] OpBranch = 7'b1100011;
  localparam logic [6:0] OpLoad   = 7'b0000011;
  localparam logic [6:0] OpStore  = 7'b0100011;
  localparam logic [6:0] OpImm    = 7'b0010011;
  localparam logic [6:0] OpReg    = 7'b0110011;

  localparam logic [6:0] F7Zero = 7'b0000000;
  localparam logic [6:0] F7Alt  = 7'b0100000;

  // funct3 codes
  localparam logic [2:0] F3Add  = 3'd0;
  localparam logic [2:0] F3Sll  = 3'd1;
  localparam logic [2:0] F3Slt  = 3'd2;
  localparam logic [2:0] F3Sltu = 3'd3;
  localparam logic [2:0] F3Xor  = 3'd4;
  localparam logic [2:0] F3Sr   = 3'd5;
  localparam logic [2:0] F3Or   = 3'd6;
  localparam logic [2:0] F3And  = 3'd7;

  localparam logic [2:0] F3Beq  = 3'd0;
  localparam logic [2:0] F3Bne  = 3'd1;
  localparam logic [2:0] F3Blt  = 3'd4;
  localparam logic [2:0] F3Bge  = 3'd5;
  localparam logic [2:0] F3Bltu = 3'd6;
  localparam logic [2:0] F3Bgeu = 3'd7;

  localparam logic [2:0] F3Byte  = 3'd0;
  localparam logic [2:0] F3Half  = 3'd1;
  localparam logic [2:0] F3Word  = 3'd2;
  localparam logic [2:0] F3ByteU = 3'd4;
  localparam logic [2:0] F3HalfU = 3'd5;

  typedef struct packed {
    logic        is_step;
    logic [15:0] load_address;
    logic [7:0]  load_byte;
  } item_t;

  typedef struct packed {
    logic             re;
    logic             we;
    logic [AddrW-1:0] addr;
    logic [3:0]       be;
    logic [31:0]      wdata;
  } mem_req_t;

  typedef struct packed {
    logic        bad_instruction;
    logic [31:0] write_value;
    logic [4:0]  dest_register;
    logic        wrote_register;
    logic [31:0] next_pc;
    logic [7:0]  exit_code;
    logic        halted;
  } result_t;

endpackage

/* rtl/rv32i_instruction_step.sv */
// RV32I step core: program byte writes and single-instruction steps over a stream port.
// Throughput: one byte write per cycle while memory is not clearing and the result register
// is free or being taken; a step runs fetch, register read and execute, and a load adds a
// data read, through the banked memory's registered read port, before the next word is taken.
// Reset: asynchronous, active low; then a clearing pass zeroes memory row by row (MemRows, 16384
// rows) before the first word leaves the queue. Uses rvis_pkg, rvis_front/mem/back.
module rv32i_instruction_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // load_address[15:0], load_byte[23:16]
  input  logic        s_axis_tuser_i,   // operation[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o    // halted[0], exit_code[8:1], next_pc[40:9],
                                        // wrote_register[41], dest_register[46:42],
                                        // write_value[78:47], bad_instruction[79]
);

  rvis_pkg::item_t    in_item, q_item;
  rvis_pkg::mem_req_t mem_req;
  rvis_pkg::result_t  res;
  logic               q_valid, q_pop, mem_busy;
  logic [31:0]        mem_rdata;

  // pack the incoming word; operation is the selector
  assign in_item.is_step      = s_axis_tuser_i;
  assign in_item.load_address = s_axis_tdata_i[15:0];
  assign in_item.load_byte    = s_axis_tdata_i[23:16];

  // front: accept and hold words so the executor can stall on its own
  rvis_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .item_valid_o (q_valid),
    .pop_i        (q_pop),
    .item_o       (q_item)
  );

  // byte memory, four banks wide
  rvis_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  // back: fetch, decode, execute, write back, hold the result word
  rvis_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (q_pop),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .mem_busy_i   (mem_busy),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  // result struct is declared lowest field last, so it packs straight onto tdata
  assign m_axis_tdata_o = res;

endmodule

/* rtl/rvis_front.sv */
// Front of the step core: accepts input words and holds them in a two-entry queue.
// Depends on rvis_pkg for the item type.
module rvis_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rvis_pkg::item_t      in_item_i,
  output logic                 item_valid_o,
  input  logic                 pop_i,
  output rvis_pkg::item_t      item_o
);

  rvis_pkg::item_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

/* rtl/rvis_mem.sv */
// Byte memory in four byte-wide banks, so any four consecutive bytes move in a single access.
// Depends on rvis_pkg; clears itself one row per cycle after reset.
module rvis_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rvis_pkg::mem_req_t  req_i,
  output logic [31:0]         rdata_o,
  output logic                busy_o
);

  logic [rvis_pkg::RowW:0] clr_q;
  logic [7:0]              rd_q [4];
  logic [1:0]              off_q;

  assign busy_o = !clr_q[rvis_pkg::RowW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy_o) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) off_q <= req_i.addr[1:0];
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]                 bank [rvis_pkg::MemRows];
    logic [1:0]                 idx;
    logic [rvis_pkg::AddrW-1:0] sum;
    logic [rvis_pkg::RowW-1:0]  row;

    assign idx = 2'(b) - req_i.addr[1:0];
    assign sum = req_i.addr + {{(rvis_pkg::AddrW-2){1'b0}}, idx};
    assign row = sum[rvis_pkg::AddrW-1:2];

    always_ff @(posedge clk_i) begin
      if (busy_o) begin
        bank[clr_q[rvis_pkg::RowW-1:0]] <= 8'h00;
      end else if (req_i.we && req_i.be[idx]) begin
        bank[row] <= req_i.wdata[8*idx +: 8];
      end
      if (req_i.re) rd_q[b] <= bank[row];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata_o[8*i +: 8] = rd_q[off_q + 2'(i)];
    end
  end

endmodule

/* rtl/rvis_back.sv */
// Back of the step core: sequencer, register file, decode, ALU and result register.
// Depends on rvis_pkg and drives the banked memory request.
module rvis_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  rvis_pkg::item_t     item_i,
  output logic                pop_o,
  output rvis_pkg::mem_req_t  mem_req_o,
  input  logic [31:0]         mem_rdata_i,
  input  logic                mem_busy_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output rvis_pkg::result_t   res_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_EXE  = 4'b0100,
    S_LD   = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] rf [32];
  logic [5:0]  rclr_q;
  logic        halt_q;
  logic [31:0] pc_q, a0_q;
  logic [31:0] w_q, rs1_q, rs2_q;
  logic [2:0]  f3_q;
  logic [4:0]  rd_q;
  logic        out_valid_q;
  rvis_pkg::result_t out_q, out_d;
  logic        finish;

  // decode fields
  logic [6:0]  op, f7, sf7;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [31:0] immi, imms, immb, immj, immu, alu_b, alu_r, ld_v;
  logic        alu_ok, taken, bad, wr, is_ld, is_st, halt_hit, alu_reg;
  logic [31:0] val, npc, maddr;
  logic [3:0]  be;
  logic        rf_we;
  logic [31:0] rf_wv;
  logic [4:0]  rf_wa;
  logic        start;

  assign op   = w_q[6:0];
  assign rd   = w_q[11:7];
  assign f3   = w_q[14:12];
  assign f7   = w_q[31:25];
  assign immi = {{20{w_q[31]}}, w_q[31:20]};
  assign imms = {{20{w_q[31]}}, w_q[31:25], w_q[11:7]};
  assign immb = {{19{w_q[31]}}, w_q[31], w_q[7], w_q[30:25], w_q[11:8], 1'b0};
  assign immj = {{11{w_q[31]}}, w_q[31], w_q[19:12], w_q[20], w_q[30:21], 1'b0};
  assign immu = {w_q[31:12], 12'h000};

  assign start = (state_q == S_IDLE) && item_valid_i && !mem_busy_i && rclr_q[5]
              && (!out_valid_q || res_ready_i);
  assign pop_o = start;

  // ALU shared by register and immediate forms
  always_comb begin
    alu_reg = (op == rvis_pkg::OpReg);
    if (alu_reg) begin
      alu_b = rs2_q;
      sf7   = f7;
    end else if (f3 == rvis_pkg::F3Sll || f3 == rvis_pkg::F3Sr) begin
      alu_b = {27'd0, w_q[24:20]};
      sf7   = f7;
    end else begin
      alu_b = immi;
      sf7   = rvis_pkg::F7Zero;
    end
    alu_ok = 1'b1;
    alu_r  = 32'd0;
    unique case (f3)
      rvis_pkg::F3Add: begin
        if (alu_reg && sf7 == rvis_pkg::F7Alt) alu_r = rs1_q - alu_b;
        else begin
          alu_r  = rs1_q + alu_b;
          alu_ok = !(alu_reg && sf7 != rvis_pkg::F7Zero);
        end
      end
      rvis_pkg::F3Sll: begin
        alu_r  = rs1_q << alu_b[4:0];
        alu_ok = (sf7 == rvis_pkg::F7Zero);
      end
      rvis_pkg::F3Slt: begin
        alu_r  = {31'd0, $signed(rs1_q) < $signed(alu_b)};
        alu_ok = !(alu_reg && sf7 != rvis_pkg::F7Zero);
      end
      rvis_pkg::F3Sltu: begin
        alu_r  = {31'd0, rs1_q < alu_b};
        alu_ok = !(alu_reg && sf7 != rvis_pkg::F7Zero);
      end
      rvis_pkg::F3Xor: begin
        alu_r  = rs1_q ^ alu_b;
        alu_ok = !(alu_reg && sf7 != rvis_pkg::F7Zero);
      end
      rvis_pkg::F3Sr: begin
        if (sf7 == rvis_pkg::F7Alt) alu_r = $unsigned($signed(rs1_q) >>> alu_b[4:0]);
        else alu_r = rs1_q >> alu_b[4:0];
        alu_ok = (sf7 == rvis_pkg::F7Zero) || (sf7 == rvis_pkg::F7Alt);
      end
      rvis_pkg::F3Or: begin
        alu_r  = rs1_q | alu_b;
        alu_ok = !(alu_reg && sf7 != rvis_pkg::F7Zero);
      end
      default: begin
        alu_r  = rs1_q & alu_b;
        alu_ok = !(alu_reg && sf7 != rvis_pkg::F7Zero);
      end
    endcase
  end

  // execute one fetched word
  always_comb begin
    halt_hit = (w_q == rvis_pkg::HaltWord);
    bad   = 1'b0;
    wr    = 1'b0;
    val   = 32'd0;
    npc   = pc_q + 32'd4;
    is_ld = 1'b0;
    is_st = 1'b0;
    be    = 4'b0000;
    maddr = rs1_q + immi;
    taken = 1'b0;
    unique case (op)
      rvis_pkg::OpLui:   begin val = immu; wr = 1'b1; end
      rvis_pkg::OpAuipc: begin val = pc_q + immu; wr = 1'b1; end
      rvis_pkg::OpJal: begin
        val = pc_q + 32'd4; wr = 1'b1; npc = pc_q + immj;
      end
      rvis_pkg::OpJalr: begin
        if (f3 != 3'd0) bad = 1'b1;
        else begin
          val = pc_q + 32'd4; wr = 1'b1; npc = (rs1_q + immi) & ~32'd1;
        end
      end
      rvis_pkg::OpBranch: begin
        unique case (f3)
          rvis_pkg::F3Beq:  taken = (rs1_q == rs2_q);
          rvis_pkg::F3Bne:  taken = (rs1_q != rs2_q);
          rvis_pkg::F3Blt:  taken = ($signed(rs1_q) < $signed(rs2_q));
          rvis_pkg::F3Bge:  taken = !($signed(rs1_q) < $signed(rs2_q));
          rvis_pkg::F3Bltu: taken = (rs1_q < rs2_q);
          rvis_pkg::F3Bgeu: taken = (rs1_q >= rs2_q);
          default:          bad = 1'b1;
        endcase
        if (taken) npc = pc_q + immb;
      end
      rvis_pkg::OpLoad: begin
        if (f3 == rvis_pkg::F3Byte || f3 == rvis_pkg::F3Half || f3 == rvis_pkg::F3Word
            || f3 == rvis_pkg::F3ByteU || f3 == rvis_pkg::F3HalfU) is_ld = 1'b1;
        else bad = 1'b1;
      end
      rvis_pkg::OpStore: begin
        maddr = rs1_q + imms;
        is_st = 1'b1;
        if (f3 == rvis_pkg::F3Byte) be = 4'b0001;
        else if (f3 == rvis_pkg::F3Half) be = 4'b0011;
        else if (f3 == rvis_pkg::F3Word) be = 4'b1111;
        else begin bad = 1'b1; is_st = 1'b0; end
      end
      rvis_pkg::OpImm, rvis_pkg::OpReg: begin
        val = alu_r; wr = alu_ok; bad = !alu_ok;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      npc = pc_q + 32'd4;
      wr  = 1'b0;
    end
  end

  // load data extension
  always_comb begin
    unique case (f3_q)
      rvis_pkg::F3Byte:  ld_v = {{24{mem_rdata_i[7]}}, mem_rdata_i[7:0]};
      rvis_pkg::F3Half:  ld_v = {{16{mem_rdata_i[15]}}, mem_rdata_i[15:0]};
      rvis_pkg::F3Word:  ld_v = mem_rdata_i;
      rvis_pkg::F3ByteU: ld_v = {24'd0, mem_rdata_i[7:0]};
      rvis_pkg::F3HalfU: ld_v = {16'd0, mem_rdata_i[15:0]};
      default:           ld_v = 32'd0;
    endcase
  end

  // sequencer, memory request, result and register write
  always_comb begin
    state_d   = state_q;
    mem_req_o = '0;
    finish    = 1'b0;
    rf_we     = 1'b0;
    rf_wa     = rd_q;
    rf_wv     = 32'd0;
    out_d     = '0;
    out_d.halted    = halt_q;
    out_d.exit_code = halt_q ? a0_q[7:0] : 8'd0;
    out_d.next_pc   = pc_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (!item_i.is_step) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.be    = 4'b0001;
            mem_req_o.addr  = rvis_pkg::AddrW'(item_i.load_address);
            mem_req_o.wdata = {24'd0, item_i.load_byte};
            finish = 1'b1;
          end else if (halt_q) begin
            finish = 1'b1;
          end else begin
            mem_req_o.re   = 1'b1;
            mem_req_o.addr = pc_q[rvis_pkg::AddrW-1:0];
            state_d = S_DEC;
          end
        end
      end
      S_DEC: state_d = S_EXE;
      S_EXE: begin
        if (halt_hit) begin
          finish = 1'b1;
          out_d.halted    = 1'b1;
          out_d.exit_code = a0_q[7:0];
          state_d = S_IDLE;
        end else if (is_ld) begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = maddr[rvis_pkg::AddrW-1:0];
          state_d = S_LD;
        end else begin
          if (is_st) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.be    = be;
            mem_req_o.addr  = maddr[rvis_pkg::AddrW-1:0];
            mem_req_o.wdata = rs2_q;
          end
          finish = 1'b1;
          rf_we  = wr && (rd != 5'd0);
          rf_wa  = rd;
          rf_wv  = val;
          out_d.next_pc         = npc;
          out_d.wrote_register  = rf_we;
          out_d.dest_register   = rf_we ? rd : 5'd0;
          out_d.write_value     = rf_we ? val : 32'd0;
          out_d.bad_instruction = bad;
          state_d = S_IDLE;
        end
      end
      S_LD: begin
        finish = 1'b1;
        rf_we  = (rd_q != 5'd0);
        rf_wv  = ld_v;
        out_d.next_pc        = pc_q + 32'd4;
        out_d.wrote_register = rf_we;
        out_d.dest_register  = rf_we ? rd_q : 5'd0;
        out_d.write_value    = rf_we ? ld_v : 32'd0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (!rclr_q[5]) rf[rclr_q[4:0]] <= 32'd0;
    else if (rf_we) rf[rf_wa] <= rf_wv;
    if (state_q == S_DEC) begin
      w_q   <= mem_rdata_i;
      rs1_q <= rf[mem_rdata_i[19:15]];
      rs2_q <= rf[mem_rdata_i[24:20]];
    end
    if (state_q == S_EXE) begin
      f3_q <= f3;
      rd_q <= rd;
    end
    if (finish) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rclr_q      <= 6'd0;
      halt_q      <= 1'b0;
      pc_q        <= 32'd0;
      a0_q        <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (!rclr_q[5]) rclr_q <= rclr_q + 6'd1;
      if (finish) begin
        halt_q <= out_d.halted;
        pc_q   <= out_d.next_pc;
      end
      if (rf_we && rf_wa == 5'd10) a0_q <= rf_wv;
      if (finish) out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

/* rtl/rvis_checker.sv */
// Port-level checks for the RV32I step core, bound to the top level.
// Depends only on the top level's ports.
module rvis_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o
);

  logic seen_halt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seen_halt_q <= 1'b0;
    else if (m_axis_tvalid_o && m_axis_tready_i && m_axis_tdata_o[0]) seen_halt_q <= 1'b1;
  end

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // halt is sticky
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && seen_halt_q |-> m_axis_tdata_o[0])
    else $error("halted dropped");

  // exit code only when halted
  a_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[8:1] == 8'd0)
    else $error("exit code while running");

  // a write names a nonzero register and never comes with a bad word
  a_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[41] |-> m_axis_tdata_o[46:42] != 5'd0
      && !m_axis_tdata_o[79])
    else $error("bad register write report");

endmodule

bind rv32i_instruction_step rvis_checker u_rvis_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

/* verif/rv32i_step_checker.sv */
// Checker for the RV32I step core: watches both stream channels, predicts each result word
// and compares it field by field. Depends on rvis_pkg for opcode and funct constants.
module rv32i_step_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [23:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [79:0] m_axis_tdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o,
  output int          halts_seen_o,
  output int          bad_seen_o
);

  logic [31:0]       regs [32];
  logic [7:0]        mem [rvis_pkg::MemBytes];
  logic [31:0]       pc;
  logic              halt;
  rvis_pkg::result_t expected_q [$];

  function automatic logic [31:0] rd_bytes(logic [31:0] a, int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = mem[(a + i) % rvis_pkg::MemBytes];
    return v;
  endfunction

  task automatic wr_bytes(logic [31:0] a, logic [31:0] v, int n);
    for (int i = 0; i < n; i++) mem[(a + i) % rvis_pkg::MemBytes] = v[8*i +: 8];
  endtask

  // Predict one result word and update the shadow state.
  task automatic predict_step(logic is_step, logic [15:0] la, logic [7:0] lb);
    rvis_pkg::result_t r;
    logic [31:0] w, npc, a, b, val, rs1v, rs2v, immi, ld;
    logic [6:0] op, f7;
    logic [4:0] rd;
    logic [2:0] f3;
    logic wr, bad, taken;
    r = '0;
    wr = 0; bad = 0; val = '0;
    if (!is_step) begin
      mem[la] = lb;
    end else if (!halt) begin
      w = rd_bytes(pc, 4);
      if (w == rvis_pkg::HaltWord) begin
        halt = 1;
      end else begin
        npc = pc + 4;
        op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
        rs1v = regs[w[19:15]]; rs2v = regs[w[24:20]];
        immi = {{20{w[31]}}, w[31:20]};
        case (op)
          rvis_pkg::OpLui: begin val = {w[31:12], 12'b0}; wr = 1; end
          rvis_pkg::OpAuipc: begin val = pc + {w[31:12], 12'b0}; wr = 1; end
          rvis_pkg::OpJal: begin
            val = pc + 4; wr = 1;
            npc = pc + {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
          end
          rvis_pkg::OpJalr: begin
            if (f3 != 3'd0) bad = 1;
            else begin val = pc + 4; wr = 1; npc = (rs1v + immi) & ~32'd1; end
          end
          rvis_pkg::OpBranch: begin
            taken = 0;
            case (f3)
              rvis_pkg::F3Beq:  taken = rs1v == rs2v;
              rvis_pkg::F3Bne:  taken = rs1v != rs2v;
              rvis_pkg::F3Blt:  taken = $signed(rs1v) < $signed(rs2v);
              rvis_pkg::F3Bge:  taken = $signed(rs1v) >= $signed(rs2v);
              rvis_pkg::F3Bltu: taken = rs1v < rs2v;
              rvis_pkg::F3Bgeu: taken = rs1v >= rs2v;
              default: bad = 1;
            endcase
            if (taken) npc = pc + {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
          end
          rvis_pkg::OpLoad: begin
            a = rs1v + immi;
            ld = rd_bytes(a, 4);
            case (f3)
              rvis_pkg::F3Byte:  val = {{24{ld[7]}}, ld[7:0]};
              rvis_pkg::F3Half:  val = {{16{ld[15]}}, ld[15:0]};
              rvis_pkg::F3Word:  val = ld;
              rvis_pkg::F3ByteU: val = {24'b0, ld[7:0]};
              rvis_pkg::F3HalfU: val = {16'b0, ld[15:0]};
              default: bad = 1;
            endcase
            wr = !bad;
          end
          rvis_pkg::OpStore: begin
            a = rs1v + {{20{w[31]}}, w[31:25], w[11:7]};
            case (f3)
              rvis_pkg::F3Byte: wr_bytes(a, rs2v, 1);
              rvis_pkg::F3Half: wr_bytes(a, rs2v, 2);
              rvis_pkg::F3Word: wr_bytes(a, rs2v, 4);
              default: bad = 1;
            endcase
          end
          rvis_pkg::OpImm, rvis_pkg::OpReg: begin
            logic isreg;
            logic [6:0] sf7;
            isreg = (op == rvis_pkg::OpReg);
            sf7 = (isreg || f3 == rvis_pkg::F3Sll || f3 == rvis_pkg::F3Sr) ? f7
                                                                            : rvis_pkg::F7Zero;
            b = isreg ? rs2v
                      : ((f3 == rvis_pkg::F3Sll || f3 == rvis_pkg::F3Sr) ? {27'b0, w[24:20]}
                                                                         : immi);
            wr = 1;
            case (f3)
              rvis_pkg::F3Add: begin
                if (isreg && sf7 == rvis_pkg::F7Alt) val = rs1v - b;
                else if (sf7 != rvis_pkg::F7Zero) bad = 1;
                else val = rs1v + b;
              end
              rvis_pkg::F3Sll: if (sf7 != rvis_pkg::F7Zero) bad = 1; else val = rs1v << b[4:0];
              rvis_pkg::F3Sr: begin
                if (sf7 == rvis_pkg::F7Zero) val = rs1v >> b[4:0];
                else if (sf7 == rvis_pkg::F7Alt) val = $unsigned($signed(rs1v) >>> b[4:0]);
                else bad = 1;
              end
              default: begin
                if (sf7 != rvis_pkg::F7Zero) bad = 1;
                else case (f3)
                  rvis_pkg::F3Slt:  val = {31'b0, $signed(rs1v) < $signed(b)};
                  rvis_pkg::F3Sltu: val = {31'b0, rs1v < b};
                  rvis_pkg::F3Xor:  val = rs1v ^ b;
                  rvis_pkg::F3Or:   val = rs1v | b;
                  default: val = rs1v & b;
                endcase
              end
            endcase
            if (bad) wr = 0;
          end
          default: bad = 1;
        endcase
        if (bad) begin npc = pc + 4; wr = 0; end
        if (wr && rd != 5'd0) begin
          regs[rd] = val;
          r.wrote_register = 1; r.dest_register = rd; r.write_value = val;
        end
        r.bad_instruction = bad;
        pc = npc;
      end
    end
    r.halted = halt;
    r.exit_code = halt ? regs[10][7:0] : 8'd0;
    r.next_pc = pc;
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d: %s got %0h expected %0h", results_seen_o, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0; results_seen_o = 0; halts_seen_o = 0; bad_seen_o = 0;
    for (int i = 0; i < 32; i++) regs[i] = '0;
    for (int i = 0; i < rvis_pkg::MemBytes; i++) mem[i] = '0;
    pc = '0; halt = 0;
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Check the result word first; a word accepted at this edge cannot have produced it.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        rvis_pkg::result_t got, want;
        got = m_axis_tdata_i;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", 32'd0, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.halted !== want.halted) report_mismatch("halted", got.halted, want.halted);
          if (got.exit_code !== want.exit_code)
            report_mismatch("exit_code", got.exit_code, want.exit_code);
          if (got.next_pc !== want.next_pc) report_mismatch("next_pc", got.next_pc, want.next_pc);
          if (got.wrote_register !== want.wrote_register)
            report_mismatch("wrote_register", got.wrote_register, want.wrote_register);
          if (got.dest_register !== want.dest_register)
            report_mismatch("dest_register", got.dest_register, want.dest_register);
          if (got.write_value !== want.write_value)
            report_mismatch("write_value", got.write_value, want.write_value);
          if (got.bad_instruction !== want.bad_instruction)
            report_mismatch("bad_instruction", got.bad_instruction, want.bad_instruction);
          if (want.halted) halts_seen_o++;
          if (want.bad_instruction) bad_seen_o++;
        end
        results_seen_o++;
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_step(s_axis_tuser_i, s_axis_tdata_i[15:0], s_axis_tdata_i[23:16]);
    end
  end
endmodule

/* verif/tb_rv32i_instruction_step.sv */
// Top of the RV32I step core testbench: clock, reset, program stimulus, output backpressure
// and verdict. Depends on rvis_pkg, the core and rv32i_step_checker.
module tb_rv32i_instruction_step;

  localparam int CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;    // load_address[15:0], load_byte[23:16]
  logic        s_axis_tuser_i;    // operation[0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [79:0] m_axis_tdata_o;    // halted, exit_code, next_pc, wrote_register,
                                  // dest_register, write_value, bad_instruction
  int fail_count, pending, results_seen, halts_seen, bad_seen;
  int cycle_count;
  int words_sent;
  logic quiet_src, quiet_sink, hold_sink;
  logic [15:0] prog_ptr;

  rv32i_instruction_step uut (.*);

  rv32i_step_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen),
    .halts_seen_o(halts_seen), .bad_seen_o(bad_seen)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // Count cycles and end the run on a timeout.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("rv32i_instruction_step verification failed");
        $finish;
      end
    end
  end

  // Drive the receiver: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    m_axis_tready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) m_axis_tready_i <= 1'b0;
      else if (quiet_sink) m_axis_tready_i <= 1'b1;
      else m_axis_tready_i <= ($urandom_range(99) >= 38);
    end
  end

  // Hold the receiver off for a long stretch once, counted in cycles.
  initial begin
    hold_sink = 0;
    wait (words_sent > 500);
    hold_sink = 1;
    repeat (300) @(posedge clk_i);
    hold_sink = 0;
  end

  // Offer one word and wait for its handshake; idle randomly first.
  task automatic send_word(logic is_step, logic [15:0] addr, logic [7:0] data);
    while (!quiet_src && $urandom_range(99) < 38) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= is_step;
    s_axis_tdata_i  <= {data, addr};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic put_instr(logic [15:0] a, logic [31:0] w);
    for (int i = 0; i < 4; i++) send_word(1'b0, a + 16'(i), w[8*i +: 8]);
  endtask

  task automatic step_core();
    send_word(1'b1, 16'($urandom), 8'($urandom));
  endtask

  // Build a random instruction, mostly valid.
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    logic [6:0] ops [9];
    logic [2:0] f3;
    int k;
    ops = '{rvis_pkg::OpLui, rvis_pkg::OpAuipc, rvis_pkg::OpJal, rvis_pkg::OpJalr,
            rvis_pkg::OpBranch, rvis_pkg::OpLoad, rvis_pkg::OpStore, rvis_pkg::OpImm,
            rvis_pkg::OpReg};
    w = $urandom;
    k = $urandom_range(99);
    if (k < 90) begin
      w[6:0] = ops[$urandom_range(8)];
      f3 = w[14:12];
      if ($urandom_range(3) != 0) begin
        case (w[6:0])
          rvis_pkg::OpJalr: w[14:12] = 3'd0;
          rvis_pkg::OpReg: w[31:25] = $urandom_range(1) ? rvis_pkg::F7Alt : rvis_pkg::F7Zero;
          rvis_pkg::OpImm:
            if (f3 == rvis_pkg::F3Sll || f3 == rvis_pkg::F3Sr)
              w[31:25] = $urandom_range(1) ? rvis_pkg::F7Alt : rvis_pkg::F7Zero;
          default: ;
        endcase
      end
      // Short jumps and branches keep the program inside the loaded window most of the time.
      if (w[6:0] == rvis_pkg::OpJal || w[6:0] == rvis_pkg::OpBranch) begin
        w[31] = $urandom_range(3) == 0; w[30:25] = '0; w[19:12] = w[31] ? 8'hff : 8'h00;
      end
    end
    return w;
  endfunction

  initial begin
    logic [31:0] w;
    rst_ni = 0;
    s_axis_tvalid_i = 0;
    s_axis_tuser_i = 0;
    s_axis_tdata_i = '0;
    words_sent = 0;
    quiet_src = 0;
    quiet_sink = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme byte writes, then a short program touching several classes and the
    // special cases: x0 destination, unknown encoding, misaligned access, wrap.
    send_word(1'b0, 16'hffff, 8'hff);
    send_word(1'b0, 16'h0000, 8'h00);
    put_instr(16'h0000, {20'hfffff, 5'd10, rvis_pkg::OpLui});          // lui a0, top
    put_instr(16'h0004, {20'h80000, 5'd0, rvis_pkg::OpAuipc});         // auipc x0
    put_instr(16'h0008, {12'hfff, 5'd10, rvis_pkg::F3Byte, 5'd11, rvis_pkg::OpLoad}); // lb
    put_instr(16'h000c, 32'h0000_000f);                                 // fence: unknown
    put_instr(16'h0010, {7'h20, 5'd10, 5'd11, rvis_pkg::F3Word, 5'd3, rvis_pkg::OpStore});
    for (int i = 0; i < 8; i++) step_core();

    // Random phases: each loads a small program and steps through it; noise words mixed in.
    quiet_src = 0;
    while (words_sent < 1100) begin
      if (words_sent > 800 && words_sent < 900) begin quiet_src = 1; quiet_sink = 1; end
      else begin quiet_src = 0; quiet_sink = 0; end
      for (int a = 0; a < 16; a++) begin
        w = rand_instr();
        put_instr(16'(16'h0100 + 4 * a), w);
      end
      // Jump into the program from wherever the core stopped, using jalr off x0; the last
      // accepted word was a byte write, so the predicted pc is settled.
      put_instr(checker_i.pc[15:0], {12'h100, 5'd0, 3'd0, 5'd1, rvis_pkg::OpJalr});
      for (int s = 0; s < 12; s++) begin
        if ($urandom_range(9) == 0) send_word(1'b0, 16'($urandom), 8'($urandom));
        else step_core();
      end
    end

    // Halt at the current pc, step while halted, write a byte while halted.
    send_word(1'b0, 16'hfffe, 8'h5a);
    put_instr(checker_i.pc[15:0], rvis_pkg::HaltWord);
    step_core();
    step_core();
    send_word(1'b0, 16'h0014, 8'h13);
    step_core();

    s_axis_tvalid_i <= 1'b0;
    quiet_sink = 1;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    $display("covered %0d words, %0d results, %0d halted, %0d unknown encodings",
             words_sent, results_seen, halts_seen, bad_seen);
    if (fail_count == 0 && pending == 0) $display("rv32i_instruction_step verification clean");
    else $display("rv32i_instruction_step verification failed");
    $finish;
  end
endmodule
